/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by edge_kernel_threshold.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EKT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ekt: assertion failed");

// next-cycle implication, disabled while reset is low
`define EKT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ekt: assertion failed");

`endif

/* rtl/ekt_pkg.sv */
// ----------------------------------------------------------------------------
// ekt_pkg
// Field widths, register map, filter codes and kernel arithmetic.
// ----------------------------------------------------------------------------
package ekt_pkg;

  localparam int PIX_W    = 8;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 9;
  localparam int CFG_WD_W = 10;
  localparam int CFG_HT_W = 13;
  localparam int MODE_W   = 2;
  localparam int THR_W    = 8;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int SUM_W    = 12;

  localparam logic [CFG_WD_W-1:0] RST_WIDTH  = 10'd512;
  localparam logic [CFG_HT_W-1:0] RST_HEIGHT = 13'd512;
  localparam logic [MODE_W-1:0]   RST_MODE   = 2'd0;
  localparam logic [THR_W-1:0]    RST_THRESH = 8'd128;

  typedef enum logic [1:0] {
    MODE_PREWITT = 2'd0,
    MODE_ROBERTS = 2'd1,
    MODE_LAPLACE = 2'd2
  } filter_mode_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_THRESH = 2'd3
  } reg_idx_e;

  typedef logic [8:0][PIX_W-1:0] win_t;

  // unused mode code falls back to Laplacian
  function automatic logic signed [SUM_W-1:0] kernel_sum(input logic [MODE_W-1:0] mode,
                                                         input win_t w);
    logic signed [SUM_W-1:0] t [9];
    logic signed [SUM_W-1:0] s;
    for (int i = 0; i < 9; i++) begin
      t[i] = signed'(SUM_W'(w[i]));
    end
    case (mode)
      MODE_PREWITT: s = t[5] + t[7] + (t[8] <<< 1) - (t[0] <<< 1) - t[1] - t[3];
      MODE_ROBERTS: s = t[0] + t[1] - t[3] - t[4];
      default:      s = (t[4] <<< 2) - t[1] - t[3] - t[5] - t[7];
    endcase
    return s;
  endfunction

  function automatic logic sum_edge(input logic signed [SUM_W-1:0] s,
                                    input logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] v;
    if (s < 0) begin
      v = '0;
    end else if (s > signed'(SUM_W'(255))) begin
      v = '1;
    end else begin
      v = PIX_W'(s);
    end
    return v > thr;
  endfunction

endpackage

/* rtl/ekt_stream_if.sv */
// ----------------------------------------------------------------------------
// ekt_stream_if
// Valid/ready channels for the pixel input and the tagged edge results.
// ----------------------------------------------------------------------------
interface ekt_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ekt_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ekt_res_if;
  logic                       valid;
  logic                       ready;
  logic [ekt_pkg::ROW_W-1:0]  out_row;
  logic [ekt_pkg::COL_W-1:0]  out_col;
  logic                       edge_res;
  logic                       last_of_run;

  modport source (output valid, output out_row, output out_col, output edge_res,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input edge_res,
                  input last_of_run, output ready);
endinterface

/* rtl/edge_kernel_threshold.sv */
// ----------------------------------------------------------------------------
// edge_kernel_threshold
// Streaming 3x3 edge detector: line memory, window, kernel, threshold.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat per clock unless stalled. Each pixel
// beat reads one entry of a single line memory (two previous rows side by side,
// one read and one write port) and writes it back when the beat leaves the
// second stage, so a new pixel is taken every cycle unless the result buffer
// holds that stage. A pixel beat yields 0 to 4 result beats (two at the end of
// a row, up to four at the end of the last row); the result buffer sends one
// per cycle while the receiver is ready, and the input waits until it sends the
// last one held. Line memory contents after reset are tracked by a fill count,
// so there is no clearing pass. Configuration registers take effect at once; the
// user must write them only while the block is idle, not enforced by the block.
`include "assert_macros.svh"

module edge_kernel_threshold #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ekt_pkg::APB_AW-1:0]   paddr,
  input  logic [ekt_pkg::APB_DW-1:0]   pwdata,
  output logic [ekt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  ekt_pix_if.sink                      pix_i,
  ekt_res_if.source                    res_o
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WEW = AW + 1;
  localparam int HEW = RW + 1;
  localparam int PW  = ekt_pkg::PIX_W;

  // configuration
  logic [ekt_pkg::CFG_WD_W-1:0] cfg_width_q;
  logic [ekt_pkg::CFG_HT_W-1:0] cfg_height_q;
  logic [ekt_pkg::MODE_W-1:0]   cfg_mode_q;
  logic [ekt_pkg::THR_W-1:0]    cfg_thr_q;
  logic                         cfg_we;

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [AW-1:0]  wm1;
  logic [RW-1:0]  hm1;

  // position counters, first stage
  logic [AW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic          eor, eof, interior, in_ready, in_fire;
  logic [3:0]    emask;

  // line memory: [2*PW-1:PW] two rows up, [PW-1:0] one row up
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rdata_q;
  logic [AW:0]     fill_q;

  // second stage
  logic          s1_v_q, s1_int_q, s1_rdv_q, s1_fire;
  logic [PW-1:0] s1_pix_q;
  logic [AW-1:0] s1_c_q;
  logic [RW-1:0] s1_r_q;
  logic [3:0]    s1_mask_q;
  logic [PW-1:0] above, two_above;
  ekt_pkg::win_t win_q, win_n;
  logic signed [ekt_pkg::SUM_W-1:0] ksum;
  logic [3:0]    s1_edge;

  // result buffer
  logic [3:0]    hold_mask_q, hold_edge_q, low, rem;
  logic [AW-1:0] hold_c_q;
  logic [RW-1:0] hold_r_q;
  logic          out_fire, hold_free;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= ekt_pkg::RST_WIDTH;
      cfg_height_q <= ekt_pkg::RST_HEIGHT;
      cfg_mode_q   <= ekt_pkg::RST_MODE;
      cfg_thr_q    <= ekt_pkg::RST_THRESH;
    end else if (cfg_we) begin
      unique case (ekt_pkg::reg_idx_e'(paddr[3:2]))
        ekt_pkg::REG_WIDTH:  cfg_width_q  <= pwdata[ekt_pkg::CFG_WD_W-1:0];
        ekt_pkg::REG_HEIGHT: cfg_height_q <= pwdata[ekt_pkg::CFG_HT_W-1:0];
        ekt_pkg::REG_MODE:   cfg_mode_q   <= pwdata[ekt_pkg::MODE_W-1:0];
        ekt_pkg::REG_THRESH: cfg_thr_q    <= pwdata[ekt_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ekt_pkg::reg_idx_e'(paddr[3:2]))
      ekt_pkg::REG_WIDTH:  prdata = ekt_pkg::APB_DW'(cfg_width_q);
      ekt_pkg::REG_HEIGHT: prdata = ekt_pkg::APB_DW'(cfg_height_q);
      ekt_pkg::REG_MODE:   prdata = ekt_pkg::APB_DW'(cfg_mode_q);
      ekt_pkg::REG_THRESH: prdata = ekt_pkg::APB_DW'(cfg_thr_q);
      default:             prdata = '0;
    endcase
  end

  // effective frame size, clamped to 3..MAX
  always_comb begin
    if (cfg_width_q < 10'd3) begin
      w_eff = WEW'(3);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(cfg_width_q);
    end
    if (cfg_height_q < 13'd3) begin
      h_eff = HEW'(3);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(cfg_height_q);
    end
  end

  assign wm1 = AW'(w_eff - WEW'(1));
  assign hm1 = RW'(h_eff - HEW'(1));

  // ---------------- first stage: position and memory read ----------------
  assign eor      = c_q >= wm1;
  assign eof      = r_q >= hm1;
  assign interior = (r_q >= RW'(2)) && (r_q <= hm1) && (c_q >= AW'(2)) && (c_q <= wm1);
  assign emask    = {eof && eor, eof && (c_q != '0), (r_q != '0) && eor,
                     (r_q != '0) && (c_q != '0)};

  assign in_ready    = !s1_v_q || s1_fire;
  assign pix_i.ready = in_ready;
  assign in_fire     = pix_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else if (in_fire) begin
      if (eor) begin
        c_q <= '0;
        r_q <= eof ? '0 : r_q + RW'(1);
      end else begin
        c_q <= c_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_c_q] <= {above, s1_pix_q};
    end
    if (in_fire) begin
      rdata_q <= line_mem[c_q];
    end
  end

  // columns are written in order from zero, so entries below fill_q are valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (s1_fire && ({1'b0, s1_c_q} == fill_q)) begin
      fill_q <= fill_q + WEW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pix_i.pixel;
      s1_c_q    <= c_q;
      s1_r_q    <= r_q;
      s1_mask_q <= emask;
      s1_int_q  <= interior;
      s1_rdv_q  <= {1'b0, c_q} < fill_q;
    end
  end

  // ---------------- second stage: window, kernel, threshold ----------------
  assign above     = s1_rdv_q ? rdata_q[PW-1:0]    : '0;
  assign two_above = s1_rdv_q ? rdata_q[2*PW-1:PW] : '0;

  always_comb begin
    win_n    = win_q;
    win_n[0] = win_q[1];
    win_n[1] = win_q[2];
    win_n[2] = two_above;
    win_n[3] = win_q[4];
    win_n[4] = win_q[5];
    win_n[5] = above;
    win_n[6] = win_q[7];
    win_n[7] = win_q[8];
    win_n[8] = s1_pix_q;
  end

  assign ksum       = ekt_pkg::kernel_sum(cfg_mode_q, win_n);
  assign s1_edge[0] = s1_int_q ? ekt_pkg::sum_edge(ksum, cfg_thr_q) : (win_n[4] > cfg_thr_q);
  assign s1_edge[1] = win_n[5] > cfg_thr_q;
  assign s1_edge[2] = win_n[7] > cfg_thr_q;
  assign s1_edge[3] = win_n[8] > cfg_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      win_q <= win_n;
    end
  end

  // ---------------- result buffer ----------------
  assign low       = hold_mask_q & (~hold_mask_q + 4'd1);
  assign rem       = hold_mask_q & ~low;
  assign out_fire  = res_o.valid && res_o.ready;
  assign hold_free = (hold_mask_q == '0) || (out_fire && (rem == '0));
  assign s1_fire   = s1_v_q && hold_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_mask_q <= '0;
    end else if (s1_fire) begin
      hold_mask_q <= s1_mask_q;
    end else if (out_fire) begin
      hold_mask_q <= rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      hold_edge_q <= s1_edge;
      hold_c_q    <= s1_c_q;
      hold_r_q    <= s1_r_q;
    end
  end

  // slot 0: up-left, slot 1: up, slot 2: left, slot 3: current pixel
  assign res_o.valid       = hold_mask_q != '0;
  assign res_o.out_row     = ekt_pkg::ROW_W'((low[0] || low[1]) ? hold_r_q - RW'(1) : hold_r_q);
  assign res_o.out_col     = ekt_pkg::COL_W'((low[0] || low[2]) ? hold_c_q - AW'(1) : hold_c_q);
  assign res_o.edge_res    = |(low & hold_edge_q);
  assign res_o.last_of_run = rem == '0;

  // ---------------- assertions ----------------
  `EKT_ASSERT_IMP(a_no_rw_same_entry, clk_i, rst_ni, in_fire && s1_fire, c_q != s1_c_q)
  `EKT_ASSERT_IMP(a_write_within_fill, clk_i, rst_ni, s1_fire, {1'b0, s1_c_q} <= fill_q)
  `EKT_ASSERT_NXT(a_stage_holds, clk_i, rst_ni, s1_v_q && !s1_fire,
                  s1_v_q && $stable(s1_c_q) && $stable(rdata_q))

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for edge_kernel_threshold: drives pixel beats and APB
// register writes, predicts every tagged edge beat in a local line-store and
// window model, and compares each result beat in order under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RANDOM_ITEMS = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [ekt_pkg::ROW_W-1:0] row;
    logic [ekt_pkg::COL_W-1:0] col;
    logic                      edge_bit;
    logic                      last;
  } edge_beat_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ekt_pkg::APB_AW-1:0] paddr;
  logic [ekt_pkg::APB_DW-1:0] pwdata;
  logic [ekt_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  ekt_pix_if pix ();
  ekt_res_if res ();

  edge_kernel_threshold i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix),
    .res_o   (res)
  );

  // local copy of the block state and registers
  logic [ekt_pkg::PIX_W-1:0]    prev_line  [MAX_WIDTH];
  logic [ekt_pkg::PIX_W-1:0]    prev2_line [MAX_WIDTH];
  int                           win [9];
  int                           row_pos;
  int                           col_pos;
  logic [ekt_pkg::CFG_WD_W-1:0] cfg_width;
  logic [ekt_pkg::CFG_HT_W-1:0] cfg_height;
  logic [ekt_pkg::MODE_W-1:0]   cfg_mode;
  logic [ekt_pkg::THR_W-1:0]    cfg_thresh;

  edge_beat_t pending_edges [$];
  int         mismatch_count;
  bit         quiet;
  bit         hold_request;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2_000_000;
    $display("** edge_kernel_threshold: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ekt_pkg::PIX_W-1:0] pick_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    return ekt_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int kernel_response();
    int s;
    case (cfg_mode)
      ekt_pkg::MODE_PREWITT: s = -2 * win[0] - win[1] - win[3] + win[5] + win[7] + 2 * win[8];
      ekt_pkg::MODE_ROBERTS: s = win[0] + win[1] - win[3] - win[4];
      default:               s = 4 * win[4] - win[1] - win[3] - win[5] - win[7];
    endcase
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s;
  endfunction

  // advance the local state by one pixel and queue the edge beats it causes
  function automatic void predict_edges(input logic [ekt_pkg::PIX_W-1:0] p);
    edge_beat_t fresh [$];
    edge_beat_t b;
    int w, h, r, c, idx, v;
    bit eor, eof, interior;
    w = (cfg_width < 3) ? 3 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    h = (cfg_height < 3) ? 3 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height));
    r = row_pos;
    c = col_pos;
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    eor = c >= w - 1;
    eof = r >= h - 1;
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = prev2_line[idx];
    win[5] = prev_line[idx];
    win[8] = p;
    prev2_line[idx] = prev_line[idx];
    prev_line[idx]  = p;
    b.last = 1'b0;
    if (r >= 1 && c >= 1) begin
      interior = (r - 1 >= 1) && (r - 1 <= h - 2) && (c - 1 >= 1) && (c - 1 <= w - 2);
      v = interior ? kernel_response() : win[4];
      b.row = ekt_pkg::ROW_W'(r - 1); b.col = ekt_pkg::COL_W'(c - 1);
      b.edge_bit = v > cfg_thresh;
      fresh.push_back(b);
    end
    if (r >= 1 && eor) begin
      b.row = ekt_pkg::ROW_W'(r - 1); b.col = ekt_pkg::COL_W'(c);
      b.edge_bit = win[5] > cfg_thresh;
      fresh.push_back(b);
    end
    if (eof && c >= 1) begin
      b.row = ekt_pkg::ROW_W'(r); b.col = ekt_pkg::COL_W'(c - 1);
      b.edge_bit = win[7] > cfg_thresh;
      fresh.push_back(b);
    end
    if (eof && eor) begin
      b.row = ekt_pkg::ROW_W'(r); b.col = ekt_pkg::COL_W'(c);
      b.edge_bit = win[8] > cfg_thresh;
      fresh.push_back(b);
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) pending_edges.push_back(fresh[i]);
    if (eor) begin
      col_pos = 0;
      row_pos = eof ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_pixel(input logic [ekt_pkg::PIX_W-1:0] p);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    do @(posedge clk_i); while (!pix.ready);
    predict_edges(p);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register
  task automatic cfg_write(input ekt_pkg::reg_idx_e idx, input int unsigned value);
    logic [ekt_pkg::APB_DW-1:0] want;
    logic [ekt_pkg::APB_DW-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ekt_pkg::REG_WIDTH: begin
        cfg_width = value[ekt_pkg::CFG_WD_W-1:0];
        want = ekt_pkg::APB_DW'(cfg_width);
      end
      ekt_pkg::REG_HEIGHT: begin
        cfg_height = value[ekt_pkg::CFG_HT_W-1:0];
        want = ekt_pkg::APB_DW'(cfg_height);
      end
      ekt_pkg::REG_MODE: begin
        cfg_mode = value[ekt_pkg::MODE_W-1:0];
        want = ekt_pkg::APB_DW'(cfg_mode);
      end
      default: begin
        cfg_thresh = value[ekt_pkg::THR_W-1:0];
        want = ekt_pkg::APB_DW'(cfg_thresh);
      end
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch($sformatf("register %s read back", idx.name()),
                                      got, want);
  endtask

  task automatic set_frame(input int unsigned wv, input int unsigned hv,
                           input int unsigned mode, input int unsigned thr);
    wait_idle();
    cfg_write(ekt_pkg::REG_WIDTH, wv);
    cfg_write(ekt_pkg::REG_HEIGHT, hv);
    cfg_write(ekt_pkg::REG_MODE, mode);
    cfg_write(ekt_pkg::REG_THRESH, thr);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_ready_gen
    int stall;
    stall = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && $urandom_range(0, 99) < 25) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        stall--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_edges
    edge_beat_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_edges.size() == 0) begin
        report_mismatch("unexpected result beat, col", res.out_col, -1);
      end else begin
        want = pending_edges.pop_front();
        if (res.out_row !== want.row) report_mismatch("out_row", res.out_row, want.row);
        if (res.out_col !== want.col) report_mismatch("out_col", res.out_col, want.col);
        if (res.edge_res !== want.edge_bit)
          report_mismatch($sformatf("edge_res at (%0d,%0d)", want.row, want.col),
                          res.edge_res, want.edge_bit);
        if (res.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run at (%0d,%0d)", want.row, want.col),
                          res.last_of_run, want.last);
      end
    end
  end

  // 3x3 frames: strong Prewitt gradient, Roberts at the top threshold,
  // and the unused mode code acting as Laplacian with a negative sum
  task automatic test_kernel_modes();
    logic [ekt_pkg::PIX_W-1:0] ramp [9] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
                                            8'h00, 8'hFF, 8'hFF};
    logic [ekt_pkg::PIX_W-1:0] check [9] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                             8'hFF, 8'h00, 8'hFF};
    logic [ekt_pkg::PIX_W-1:0] pit [9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
                                           8'hFF, 8'hFF, 8'hFF};
    set_frame(3, 3, ekt_pkg::MODE_PREWITT, 0);
    foreach (ramp[i]) send_pixel(ramp[i]);
    set_frame(3, 3, ekt_pkg::MODE_ROBERTS, 255);
    foreach (check[i]) send_pixel(check[i]);
    set_frame(3, 3, 3, 0);
    foreach (pit[i]) send_pixel(pit[i]);
  endtask

  task automatic test_random_frames();
    int sent, roll, wv, hv, thr, wc, hc, count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      wv = (roll == 0) ? $urandom_range(0, 2) :
           (roll == 1) ? $urandom_range(513, 1023) : $urandom_range(3, 8);
      roll = $urandom_range(0, 9);
      hv = (roll == 0) ? $urandom_range(0, 2) :
           (roll == 1) ? $urandom_range(4097, 8191) : $urandom_range(3, 6);
      roll = $urandom_range(0, 9);
      thr = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
      set_frame(wv, hv, $urandom_range(0, 3), thr);
      wc = (wv < 3) ? 3 : wv;
      hc = (hv < 3) ? 3 : hv;
      count = (wc * hc <= 12) ? wc * hc : 12;
      quiet = ($urandom_range(0, 3) == 0);
      repeat (count) send_pixel(pick_pixel());
      quiet = 1'b0;
      sent += count;
    end
  endtask

  // long result hold-off while pixels keep coming: input must stall
  task automatic test_output_stall();
    set_frame(4, 3, ekt_pkg::MODE_LAPLACE, $urandom_range(0, 255));
    quiet = 1'b1;
    hold_request = 1'b1;
    repeat (16) send_pixel(pick_pixel());
    quiet = 1'b0;
  endtask

  // size registers shrink below the running row and column counters
  task automatic test_resize_midframe();
    set_frame(4, 8191, ekt_pkg::MODE_PREWITT, 100);
    repeat (20) send_pixel(pick_pixel());
    set_frame(4, 5, ekt_pkg::MODE_ROBERTS, 20);
    repeat (6) send_pixel(pick_pixel());
    set_frame(1023, 4, ekt_pkg::MODE_PREWITT, 60);
    repeat (6) send_pixel(pick_pixel());
    set_frame(3, 4, ekt_pkg::MODE_LAPLACE, 60);
    repeat (6) send_pixel(pick_pixel());
  endtask

  task automatic test_wide_frame();
    set_frame(MAX_WIDTH, 3, $urandom_range(0, 3), $urandom_range(0, 255));
    repeat (8) send_pixel(pick_pixel());
  endtask

  initial begin : main
    mismatch_count = 0;
    quiet          = 1'b0;
    hold_request   = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pix.valid      = 1'b0;
    pix.pixel      = '0;
    foreach (prev_line[i]) begin
      prev_line[i]  = '0;
      prev2_line[i] = '0;
    end
    foreach (win[i]) win[i] = 0;
    row_pos    = 0;
    col_pos    = 0;
    cfg_width  = ekt_pkg::RST_WIDTH;
    cfg_height = ekt_pkg::RST_HEIGHT;
    cfg_mode   = ekt_pkg::RST_MODE;
    cfg_thresh = ekt_pkg::RST_THRESH;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_kernel_modes();
    test_random_frames();
    test_output_stall();
    test_resize_midframe();
    test_wide_frame();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (pending_edges.size() != 0)
      report_mismatch("result beats never seen", 0, pending_edges.size());
    if (mismatch_count == 0) begin
      $display("** edge_kernel_threshold: PASSED **");
    end else begin
      $display("** edge_kernel_threshold: FAILED **");
    end
    $finish;
  end

endmodule
